/* sv/wstd_pkg.sv */
package wstd_pkg;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_FULL       = 2'd1;
    localparam logic [1:0] ST_BAD_WORKER = 2'd2;

    localparam int unsigned REG_WORKERS_IN_USE = 0;

    localparam int unsigned TASK_BITS   = 64;
    localparam int unsigned WORKER_BITS = 3;
    localparam int unsigned NACT_BITS   = 4;

    typedef struct packed {
        logic [TASK_BITS-1:0]   task_out;
        logic                   found;
        logic                   stolen;
        logic [WORKER_BITS-1:0] source_worker;
        logic [1:0]             status;
    } t_res;

endpackage

/* sv/wstd_ram.sv */
module wstd_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 512
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/wstd_seq.sv */
module wstd_seq #(
    parameter int unsigned WORKERS     = 8,
    parameter int unsigned QUEUE_DEPTH = 64,
    parameter int unsigned HANDLE_BITS = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic                                  i_op,
    input  logic [wstd_pkg::WORKER_BITS-1:0]      i_worker,
    input  logic [wstd_pkg::TASK_BITS-1:0]        i_task_id,
    input  logic [wstd_pkg::NACT_BITS-1:0]        i_nact,
    output logic                                  o_res_valid,
    input  logic                                  i_res_ready,
    output wstd_pkg::t_res                        o_res
);

    localparam int unsigned WB = (WORKERS > 1) ? $clog2(WORKERS) : 1;
    localparam int unsigned PW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned MW = 2 * PW + CW;
    localparam int unsigned QN = WORKERS * QUEUE_DEPTH;
    localparam int unsigned AW = $clog2(QN);
    localparam int unsigned NB = wstd_pkg::NACT_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MRD,
        S_MUSE,
        S_QRD,
        S_DONE
    } t_state;

    t_state                 r_state;
    logic                   r_op;
    logic                   r_steal;
    logic [WB-1:0]          r_cur;
    logic [NB-1:0]          r_cand;
    logic [NB-1:0]          r_step;
    logic [HANDLE_BITS-1:0] r_handle;
    logic [WORKERS-1:0]     r_nonempty;
    logic [WORKERS-1:0]     r_meta_vld;
    wstd_pkg::t_res         r_res;

    logic [HANDLE_BITS-1:0] in_handle;
    logic                   in_bad;
    logic [WB-1:0]          in_widx;
    logic [NB-1:0]          in_first;
    logic [NB-1:0]          n_cand;
    logic [MW-1:0]          m_rdata;
    logic [MW-1:0]          m_cur;
    logic [MW-1:0]          m_wdata;
    logic [PW-1:0]          m_head;
    logic [PW-1:0]          m_tail;
    logic [CW-1:0]          m_cnt;
    logic                   m_full;
    logic [PW-1:0]          m_prev;
    logic [PW-1:0]          m_next_tail;
    logic [PW-1:0]          m_next_head;
    logic [PW-1:0]          q_ptr;
    logic [AW-1:0]          q_addr;
    logic                   q_we;
    logic                   q_re;
    logic [HANDLE_BITS-1:0] q_rdata;
    logic                   meta_we;
    logic                   meta_re;

    assign in_handle = i_task_id[HANDLE_BITS-1:0];
    assign in_bad    = (NB'(i_worker) >= i_nact);
    assign in_widx   = WB'(i_worker);
    assign in_first  = (NB'(i_worker) + NB'(1) == i_nact) ? '0 : NB'(i_worker) + NB'(1);
    assign n_cand    = (r_cand + NB'(1) == i_nact) ? '0 : r_cand + NB'(1);

    assign m_cur  = r_meta_vld[r_cur] ? m_rdata : '0;
    assign m_head = m_cur[MW-1 -: PW];
    assign m_tail = m_cur[CW +: PW];
    assign m_cnt  = m_cur[CW-1:0];
    assign m_full = (m_cnt >= CW'(QUEUE_DEPTH));

    assign m_prev      = (m_tail == '0) ? PW'(QUEUE_DEPTH - 1) : m_tail - PW'(1);
    assign m_next_tail = (m_tail == PW'(QUEUE_DEPTH - 1)) ? '0 : m_tail + PW'(1);
    assign m_next_head = (m_head == PW'(QUEUE_DEPTH - 1)) ? '0 : m_head + PW'(1);

    always_comb begin
        if (r_op == wstd_pkg::OP_INSERT) begin
            q_ptr   = m_tail;
            m_wdata = {m_head, m_next_tail, m_cnt + CW'(1)};
        end else if (r_steal) begin
            q_ptr   = m_head;
            m_wdata = {m_next_head, m_tail, m_cnt - CW'(1)};
        end else begin
            q_ptr   = m_prev;
            m_wdata = {m_head, m_prev, m_cnt - CW'(1)};
        end
    end

    assign q_addr  = AW'(r_cur) * AW'(QUEUE_DEPTH) + AW'(q_ptr);
    assign q_we    = (r_state == S_MUSE) && (r_op == wstd_pkg::OP_INSERT) && !m_full;
    assign q_re    = (r_state == S_MUSE) && (r_op == wstd_pkg::OP_REMOVE);
    assign meta_we = (r_state == S_MUSE) && !((r_op == wstd_pkg::OP_INSERT) && m_full);
    assign meta_re = (r_state == S_MRD);

    wstd_ram #(
        .WIDTH (HANDLE_BITS),
        .DEPTH (QN)
    ) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (q_addr),
        .i_wdata (r_handle),
        .i_re    (q_re),
        .i_raddr (q_addr),
        .o_rdata (q_rdata)
    );

    wstd_ram #(
        .WIDTH (MW),
        .DEPTH (WORKERS)
    ) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (r_cur),
        .i_wdata (m_wdata),
        .i_re    (meta_re),
        .i_raddr (r_cur),
        .o_rdata (m_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_nonempty <= '0;
            r_meta_vld <= '0;
            r_res      <= '0;
            r_op       <= wstd_pkg::OP_INSERT;
            r_steal    <= 1'b0;
            r_cur      <= '0;
            r_cand     <= '0;
            r_step     <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_res.task_out      <= '0;
                        r_res.found         <= 1'b0;
                        r_res.stolen        <= 1'b0;
                        r_res.source_worker <= '0;
                        r_res.status        <= in_bad ? wstd_pkg::ST_BAD_WORKER
                                                      : wstd_pkg::ST_OK;
                        r_op     <= i_op;
                        r_handle <= in_handle;
                        r_cur    <= in_widx;
                        r_steal  <= 1'b0;
                        r_cand   <= in_first;
                        r_step   <= NB'(1);
                        if (in_bad) begin
                            r_state <= S_DONE;
                        end else if (i_op == wstd_pkg::OP_INSERT) begin
                            r_state <= (in_handle == '0) ? S_DONE : S_MRD;
                        end else begin
                            r_state <= r_nonempty[in_widx] ? S_MRD : S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_step >= i_nact) begin
                        r_state <= S_DONE;
                    end else if (r_nonempty[WB'(r_cand)]) begin
                        r_cur   <= WB'(r_cand);
                        r_steal <= 1'b1;
                        r_state <= S_MRD;
                    end else begin
                        r_cand <= n_cand;
                        r_step <= r_step + NB'(1);
                    end
                end
                S_MRD: begin
                    r_state <= S_MUSE;
                end
                S_MUSE: begin
                    if (r_op == wstd_pkg::OP_INSERT) begin
                        if (m_full) begin
                            r_res.status <= wstd_pkg::ST_FULL;
                        end else begin
                            r_meta_vld[r_cur] <= 1'b1;
                            r_nonempty[r_cur] <= 1'b1;
                        end
                        r_state <= S_DONE;
                    end else begin
                        r_meta_vld[r_cur]   <= 1'b1;
                        r_nonempty[r_cur]   <= (m_cnt != CW'(1));
                        r_res.found         <= 1'b1;
                        r_res.stolen        <= r_steal;
                        r_res.source_worker <= wstd_pkg::WORKER_BITS'(r_cur);
                        r_state             <= S_QRD;
                    end
                end
                S_QRD: begin
                    r_res.task_out <= wstd_pkg::TASK_BITS'(q_rdata);
                    r_state        <= S_DONE;
                end
                S_DONE: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUSE) |-> (m_cnt <= CW'(QUEUE_DEPTH)))
        else $error("queue occupancy beyond depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUSE && r_op == wstd_pkg::OP_REMOVE) |-> (m_cnt != '0))
        else $error("pop from a queue whose count is zero");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_res.found) |-> (r_res.status == wstd_pkg::ST_OK))
        else $error("task returned with error status");

    a_steal_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_step < i_nact && r_nonempty[WB'(r_cand)]) |=>
        (r_state == S_MRD && r_steal))
        else $error("nonempty victim skipped");
`endif

endmodule

/* sv/work_stealing_task_deques.sv */
// A bad worker or a zero-handle insert completes without touching the queues. A remove
// from an empty own queue scans the other workers in turn (up to workers_in_use - 1 of
// them) to steal from. One transaction at a time: the next is accepted in the cycle
// after the result leaves the sequencer.
// Synchronous active-low reset empties all queues and sets workers_in_use to
// min(8, WORKERS); queue memory contents are not cleared.
module work_stealing_task_deques #(
    parameter int unsigned WORKERS     = 8,
    parameter int unsigned QUEUE_DEPTH = 64,
    parameter int unsigned HANDLE_BITS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_op,
    input  logic [2:0]  i_worker,
    input  logic [63:0] i_task_id,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_task_out,
    output logic        o_found,
    output logic        o_stolen,
    output logic [2:0]  o_source_worker,
    output logic [1:0]  o_status
);

    localparam int unsigned NB = wstd_pkg::NACT_BITS;
    localparam logic [NB-1:0] WIU_RESET = (WORKERS < 8) ? NB'(WORKERS) : NB'(8);

    logic [NB-1:0]  r_wiu;
    logic [NB-1:0]  nact;
    logic           cfg_sel;
    logic           res_valid;
    logic           res_ready;
    wstd_pkg::t_res res;
    logic           r_o_valid;
    wstd_pkg::t_res r_out;

    assign pready  = 1'b1;
    assign cfg_sel = (32'(paddr[2]) == 32'(wstd_pkg::REG_WORKERS_IN_USE));
    assign prdata  = cfg_sel ? 32'(r_wiu) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wiu <= WIU_RESET;
        end else if (psel && penable && pwrite && pready && cfg_sel) begin
            r_wiu <= pwdata[NB-1:0];
        end
    end

    always_comb begin
        if (r_wiu == '0) begin
            nact = NB'(1);
        end else if (8'(r_wiu) > 8'(WORKERS)) begin
            nact = NB'(WORKERS);
        end else begin
            nact = r_wiu;
        end
    end

    wstd_seq #(
        .WORKERS     (WORKERS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_op        (i_op),
        .i_worker    (i_worker),
        .i_task_id   (i_task_id),
        .i_nact      (nact),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    assign res_ready = !r_o_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (res_ready) begin
            r_o_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_task_out      = r_out.task_out;
    assign o_found         = r_out.found;
    assign o_stolen        = r_out.stolen;
    assign o_source_worker = r_out.source_worker;
    assign o_status        = r_out.status;

endmodule
